// ===== hw/rtl/tilt_angle_level_alarm_macros.svh =====
// Assertion macros shared by the tilt alarm checker
`ifndef TILT_ANGLE_LEVEL_ALARM_MACROS_SVH
`define TILT_ANGLE_LEVEL_ALARM_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TILT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TILT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tilt_pkg.sv =====
// Types, constants and the arctangent table of the tilt angle alarm
package tilt_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ITER_W           = $clog2(ANGLE_ITERATIONS);
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IDX_W       = $clog2(ATAN_LEN);

  localparam int THR_W    = 15;
  localparam int MID_W    = 13;
  localparam int CFG_W    = 15;
  localparam int CENT_W   = SAMPLE_BITS + 2;       // centered sample, signed
  localparam int FRAC_SH  = 16;                    // operand pre-scale
  localparam int CORDIC_W = CENT_W + FRAC_SH + 3;  // room for CORDIC gain
  localparam int Z_W      = 25;                    // degrees * 2^16, signed
  localparam int ANGLE_W  = 16;
  localparam int CLS_W    = 2;

  localparam int Q8_90DEG = 23040;

  // register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MIDSCALE  = 1'b1;

  // level classes
  localparam logic [CLS_W-1:0] CLS_NORMAL = 2'd0;
  localparam logic [CLS_W-1:0] CLS_HIGH   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOW    = 2'd2;
  localparam logic [CLS_W-1:0] CLS_EDGE   = 2'd3;

  typedef struct packed {
    logic led_high;
    logic led_low;
    logic buzzer;
  } led_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    led_t             leds;
  } alarm_res_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic logic signed [Z_W-1:0] atan_deg16(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tilt_cordic.sv =====
// Iterative vectoring CORDIC: one shift/add-sub step per cycle
module tilt_cordic
  import tilt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [CORDIC_W-1:0] x_init,
  input  logic signed [CORDIC_W-1:0] y_init,
  output logic                       done,
  output logic signed [Z_W-1:0]      z_out
);

  logic signed [CORDIC_W-1:0] x_r, x_nxt;
  logic signed [CORDIC_W-1:0] y_r, y_nxt;
  logic signed [Z_W-1:0]      z_r, z_nxt;
  logic [ITER_W-1:0]          idx_r, idx_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic signed [Z_W-1:0]      dz;

  // the one shared step unit
  assign dx = y_r >>> idx_r;
  assign dy = x_r >>> idx_r;
  assign dz = atan_deg16(ATAN_IDX_W'(idx_r));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x_init;
      y_nxt    = y_init;
      z_nxt    = '0;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[CORDIC_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + dz;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - dz;
      end
      idx_nxt = idx_r + 1'b1;
      if (idx_r == ITER_W'(ANGLE_ITERATIONS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

// ===== hw/rtl/tilt_alarm.sv =====
// Threshold classification and LED / buzzer state
module tilt_alarm
  import tilt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      update,
  input  logic                      defined,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [THR_W-1:0]          threshold,
  output alarm_res_t                res
);

  led_t leds_r, leds_nxt;
  logic [CLS_W-1:0] cls;
  logic signed [ANGLE_W:0] ang_x, thr_p, thr_n;

  assign ang_x = {angle[ANGLE_W-1], angle};
  assign thr_p = $signed({2'b00, threshold});
  assign thr_n = -thr_p;

  always_comb begin
    leds_nxt = leds_r;
    priority if (!defined) begin
      cls = CLS_EDGE;
    end else if (ang_x > thr_p) begin
      cls               = CLS_HIGH;
      leds_nxt.led_high = ~leds_r.led_high;
      leds_nxt.buzzer   = ~leds_r.buzzer;
      leds_nxt.led_low  = 1'b0;
    end else if (ang_x < thr_n) begin
      cls               = CLS_LOW;
      leds_nxt.led_low  = ~leds_r.led_low;
      leds_nxt.buzzer   = ~leds_r.buzzer;
      leds_nxt.led_high = 1'b0;
    end else if (ang_x > thr_n && ang_x < thr_p) begin
      cls      = CLS_NORMAL;
      leds_nxt = '{led_high: 1'b1, led_low: 1'b1, buzzer: 1'b0};
    end else begin
      cls = CLS_EDGE;  // exactly on a limit
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leds_r <= '0;
    end else if (update) begin
      leds_r <= leds_nxt;
    end
  end

  assign res.cls  = cls;
  assign res.leds = leds_nxt;

endmodule

// ===== hw/rtl/tilt_angle_level_alarm.sv =====
// Tilt angle level alarm: top level with sequencer and output register
//
//   channel | beat           | direction | fields
//   in_     | one Y/Z pair   | in        | y_sample, z_sample
//   out_    | one result     | out       | angle_q8, level_class, led/buzzer levels
//   cfg_    | register write | in        | threshold_q8 (0), midscale_x2 (1)
//
// A pair that needs the arctangent passes through setup, 16 steps of the single
// shift/add-sub unit in tilt_cordic, rounding and the output load before
// out_tvalid rises; the next pair is taken once the sequencer is back in idle.
// Pairs on an axis skip the CORDIC and go from setup straight to the output load.
// in_tready is high only while idle; a result held in the output register
// stalls the last step until taken. Sync active-low reset; cfg_ready always high.
module tilt_angle_level_alarm
  import tilt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [11:0] y_sample, [23:12] z_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [15:0] angle_q8, [17:16] level_class,
                                   // [18] led_high, [19] led_low, [20] buzzer_on
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam int RND_W = Z_W - 7;

  logic [1:0] state_r, state_nxt;
  logic [THR_W-1:0] thr_r;
  logic [MID_W-1:0] mid_r;
  logic signed [CENT_W-1:0] yc_r, zc_r;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic def_r, def_nxt;
  logic out_valid_r;
  logic [23:0] out_data_r;

  logic [SAMPLE_BITS-1:0] ys, zs;
  logic signed [CENT_W-1:0] yc_in, zc_in, x_mag, y_fold;
  logic signed [CORDIC_W-1:0] x_init, y_init;
  logic cordic_start, cordic_done;
  logic signed [Z_W-1:0] z_res;
  logic signed [Z_W:0] z_sum;
  logic signed [RND_W-1:0] z_rnd;
  logic out_free, fin_fire;
  alarm_res_t ares;

  assign ys = in_tdata[SAMPLE_BITS-1:0];
  assign zs = in_tdata[SAMPLE_BITS +: SAMPLE_BITS];
  assign yc_in = $signed({1'b0, ys, 1'b0}) - $signed({1'b0, mid_r});
  assign zc_in = $signed({1'b0, zs, 1'b0}) - $signed({1'b0, mid_r});

  // fold Z's sign into Y so the CORDIC x operand is positive
  assign x_mag  = zc_r[CENT_W-1] ? -zc_r : zc_r;
  assign y_fold = zc_r[CENT_W-1] ? -yc_r : yc_r;
  assign x_init = {{(CORDIC_W-CENT_W-FRAC_SH){x_mag[CENT_W-1]}}, x_mag, {FRAC_SH{1'b0}}};
  assign y_init = {{(CORDIC_W-CENT_W-FRAC_SH){y_fold[CENT_W-1]}}, y_fold, {FRAC_SH{1'b0}}};

  // round to nearest Q8.8, ties up
  assign z_sum = {z_res[Z_W-1], z_res} + (Z_W+1)'(128);
  assign z_rnd = z_sum[Z_W:8];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_fire  = (state_r == ST_FIN) && out_free;

  always_comb begin
    state_nxt    = state_r;
    angle_nxt    = angle_r;
    def_nxt      = def_r;
    cordic_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        def_nxt = 1'b1;
        priority if (yc_r == '0 && zc_r == '0) begin
          def_nxt   = 1'b0;
          angle_nxt = '0;
          state_nxt = ST_FIN;
        end else if (zc_r == '0) begin
          angle_nxt = yc_r[CENT_W-1] ? -ANGLE_W'(Q8_90DEG) : ANGLE_W'(Q8_90DEG);
          state_nxt = ST_FIN;
        end else if (yc_r == '0) begin
          angle_nxt = '0;
          state_nxt = ST_FIN;
        end else begin
          cordic_start = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cordic_done) begin
          priority if (z_rnd > RND_W'(Q8_90DEG))
            angle_nxt = ANGLE_W'(Q8_90DEG);
          else if (z_rnd < -RND_W'(Q8_90DEG))
            angle_nxt = -ANGLE_W'(Q8_90DEG);
          else
            angle_nxt = z_rnd[ANGLE_W-1:0];
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  tilt_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cordic_start),
    .x_init (x_init),
    .y_init (y_init),
    .done   (cordic_done),
    .z_out  (z_res)
  );

  tilt_alarm u_alarm (
    .clk       (clk),
    .rst_n     (rst_n),
    .update    (fin_fire),
    .defined   (def_r),
    .angle     (angle_r),
    .threshold (thr_r),
    .res       (ares)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= THR_W'(3840);
      mid_r       <= MID_W'(4095);
    end else begin
      state_r <= state_nxt;
      if (fin_fire)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
          REG_MIDSCALE:  mid_r <= cfg_data[MID_W-1:0];
          default: ;
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      yc_r <= yc_in;
      zc_r <= zc_in;
    end
    angle_r <= angle_nxt;
    def_r   <= def_nxt;
    if (fin_fire)
      out_data_r <= {3'b000, ares.leds.buzzer, ares.leds.led_low, ares.leds.led_high,
                     ares.cls, angle_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/tilt_chk.sv =====
// Port-level checker for the tilt angle level alarm, bound to the top level
`include "tilt_angle_level_alarm_macros.svh"

module tilt_chk
  import tilt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic signed [ANGLE_W-1:0] ang;
  logic [CLS_W-1:0] cls;

  assign ang = $signed(out_tdata[ANGLE_W-1:0]);
  assign cls = out_tdata[17:16];

  `TILT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `TILT_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "second sample taken while busy")
  `TILT_ASSERT_NOW(a_angle_range, out_tvalid, ang <= ANGLE_W'(Q8_90DEG) && ang >= -ANGLE_W'(Q8_90DEG), "angle outside 90 degrees")
  `TILT_ASSERT_NOW(a_normal_leds, out_tvalid && cls == CLS_NORMAL, out_tdata[20:18] == 3'b011, "normal class with wrong indicators")
  `TILT_ASSERT_NOW(a_high_clears_low, out_tvalid && cls == CLS_HIGH, !out_tdata[19], "low LED on in high class")

endmodule

bind tilt_angle_level_alarm tilt_chk u_tilt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
